// ----- rtl/tvsd_pkg.sv -----
package tvsd_pkg;

    typedef enum logic [9:0] {
        PH_IDLE    = 10'b0000000001,
        PH_TAG     = 10'b0000000010,
        PH_VAR_INT = 10'b0000000100,
        PH_VAR_STR = 10'b0000001000,
        PH_VAR_REF = 10'b0000010000,
        PH_VAR_TAB = 10'b0000100000,
        PH_DOUBLE  = 10'b0001000000,
        PH_STRB    = 10'b0010000000,
        PH_DONE    = 10'b0100000000,
        PH_FAIL    = 10'b1000000000
    } t_phase;

    localparam logic [3:0] TK_NONE = 4'd0;
    localparam logic [3:0] TK_NIL = 4'd1;
    localparam logic [3:0] TK_FALSE = 4'd2;
    localparam logic [3:0] TK_TRUE = 4'd3;
    localparam logic [3:0] TK_INT = 4'd4;
    localparam logic [3:0] TK_DOUBLE = 4'd5;
    localparam logic [3:0] TK_NEWSTR = 4'd6;
    localparam logic [3:0] TK_STRBYTE = 4'd7;
    localparam logic [3:0] TK_STRREF = 4'd8;
    localparam logic [3:0] TK_TABLE = 4'd9;

    localparam logic [3:0] ER_NONE = 4'd0;
    localparam logic [3:0] ER_END = 4'd1;
    localparam logic [3:0] ER_TAG = 4'd2;
    localparam logic [3:0] ER_VLONG = 4'd3;
    localparam logic [3:0] ER_VTRUNC = 4'd4;
    localparam logic [3:0] ER_DTRUNC = 4'd5;
    localparam logic [3:0] ER_STRUNC = 4'd6;
    localparam logic [3:0] ER_REF = 4'd7;
    localparam logic [3:0] ER_DEEP = 4'd8;
    localparam logic [3:0] ER_BIG = 4'd9;
    localparam logic [3:0] ER_TRAIL = 4'd10;

    localparam logic [7:0] TG_NIL = 8'h00;
    localparam logic [7:0] TG_NO = 8'h01;
    localparam logic [7:0] TG_YES = 8'h02;
    localparam logic [7:0] TG_INT = 8'h03;
    localparam logic [7:0] TG_DBL = 8'h04;
    localparam logic [7:0] TG_STR = 8'h05;
    localparam logic [7:0] TG_REF = 8'h06;
    localparam logic [7:0] TG_MAP = 8'h07;

endpackage

// ----- rtl/tagged_value_stream_decoder.sv -----
// Channel  | Dir | tdata fields (low bit up)                   | tuser
// s_axis   | in  | byte_value[7:0], bytes_after[31:8]          | start_req
// m_axis   | out | token_kind[3:0], token_value[67:4],         | -
//          |     | levels_closed[74:68], message_done[75],     |
//          |     | error_code[79:76]                           |
// One byte per cycle in the common case. A completing value inside open
// tables walks the owed-count stack one level per cycle while the output register
// is free, reading each new top through the single read port of the stack RAM.
// The top of stack is cached in a register so no RAM read sits in the fast path.
// Reset (synchronous, active low) returns to idle; stack contents stay undefined.
// A result waits in the output register; s_axis stalls only while it is full
// and unread, or during a close cascade.
module tagged_value_stream_decoder #(
    parameter int MAX_DEPTH   = 64,
    parameter int LENGTH_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // byte_value[7:0], bytes_after[31:8]
    input  logic        s_axis_tuser,   // start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // kind, value, closed, done, error
);
    import tvsd_pkg::*;

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int RD = (MAX_DEPTH > 1) ? MAX_DEPTH : 2;
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int OW = LENGTH_BITS + 1;
    localparam logic [DW-1:0] DMAX = DW'(MAX_DEPTH);

    // Control state
    t_phase                 r_ph, n_ph;
    logic [63:0]            r_acc, n_acc;
    logic [6:0]             r_sh, n_sh;
    logic [LENGTH_BITS-1:0] r_pend, n_pend;
    logic [LENGTH_BITS-1:0] r_nstr, n_nstr;
    logic [DW-1:0]          r_dep, n_dep;
    logic [OW-1:0]          r_top, n_top;       // owed count of innermost table
    // Cascade state: pop levels while holding the pending token
    logic                   r_casc, n_casc;
    logic                   r_pop, n_pop;       // RAM read of new top in flight
    logic [3:0]             r_ck, n_ck;
    logic [63:0]            r_cv, n_cv;
    logic [LENGTH_BITS-1:0] r_crem, n_crem;
    logic [6:0]             r_ccl, n_ccl;
    // Output register
    logic                   r_ov, n_ov;
    logic [79:0]            r_od, n_od;

    logic                   we;
    logic [AW-1:0]          waddr, raddr;
    logic [OW-1:0]          wdata, rdata;

    tvsd_ram #(.WIDTH(OW), .DEPTH(RD)) u_stack (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic                   acc_in;
    logic                   start;
    logic [7:0]             b;
    logic [LENGTH_BITS-1:0] rem;
    logic [63:0]            vacc;
    logic [OW-1:0]          top_cur, owed;
    logic [DW-1:0]          dep_cur;
    logic                   do_cmp;
    logic [3:0]             ck;
    logic [63:0]            cv;
    logic [6:0]             ccl;
    logic                   orun_free;

    assign orun_free     = !r_ov || m_axis_tready;
    assign s_axis_tready = orun_free && !r_casc;
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign start         = s_axis_tuser;
    assign b             = s_axis_tdata[7:0];
    // Keep only the low LENGTH_BITS of the count, zero-extend past the port width
    assign rem           = LENGTH_BITS'(s_axis_tdata[31:8]);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

    function automatic logic [79:0] pack(logic [3:0] k, logic [63:0] v, logic [6:0] c,
                                         logic d, logic [3:0] e);
        return {e, d, c, v, k};
    endfunction

    always_comb begin
        n_ph = r_ph; n_acc = r_acc; n_sh = r_sh; n_pend = r_pend; n_nstr = r_nstr;
        n_dep = r_dep; n_top = r_top; n_casc = r_casc; n_pop = 1'b0;
        n_ck = r_ck; n_cv = r_cv; n_crem = r_crem; n_ccl = r_ccl;
        n_ov = r_ov && !m_axis_tready; n_od = r_od;
        we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
        vacc = r_acc; top_cur = r_top; dep_cur = r_dep;
        do_cmp = 1'b0; ck = TK_NONE; cv = '0; ccl = '0; owed = '0;

        if (r_casc) begin
            // Cascade step: the new top arrives from RAM after each pop
            if (r_pop) top_cur = rdata;
            if (orun_free) begin
                do_cmp = 1'b1; ck = r_ck; cv = r_cv; ccl = r_ccl;
            end
        end else if (acc_in) begin
            if (start) begin
                dep_cur = '0; n_dep = '0; n_nstr = '0; n_acc = '0; n_sh = '0;
                n_pend = '0; n_ph = PH_TAG;
            end
            unique case (start ? PH_TAG : r_ph)
                PH_TAG: begin
                    n_acc = '0; n_sh = '0;
                    if (b == TG_NIL || b == TG_NO || b == TG_YES) begin
                        do_cmp = 1'b1; ck = (b == TG_NIL) ? TK_NIL :
                                            (b == TG_NO) ? TK_FALSE : TK_TRUE;
                    end else if (b == TG_DBL) begin
                        if (rem < LENGTH_BITS'(8)) begin
                            n_ph = PH_FAIL; n_ov = 1'b1;
                            n_od = pack(TK_NONE, '0, '0, 1'b0, ER_DTRUNC);
                        end else begin
                            n_pend = LENGTH_BITS'(8); n_ph = PH_DOUBLE;
                        end
                    end else if (b == TG_MAP && dep_cur >= DMAX) begin
                        n_ph = PH_FAIL; n_ov = 1'b1;
                        n_od = pack(TK_NONE, '0, '0, 1'b0, ER_DEEP);
                    end else if (b == TG_INT || b == TG_STR || b == TG_REF ||
                                 b == TG_MAP) begin
                        if (rem == '0) begin
                            n_ph = PH_FAIL; n_ov = 1'b1;
                            n_od = pack(TK_NONE, '0, '0, 1'b0, ER_VTRUNC);
                        end else begin
                            n_ph = (b == TG_INT) ? PH_VAR_INT :
                                   (b == TG_STR) ? PH_VAR_STR :
                                   (b == TG_REF) ? PH_VAR_REF : PH_VAR_TAB;
                        end
                    end else begin
                        n_ph = PH_FAIL; n_ov = 1'b1;
                        n_od = pack(TK_NONE, '0, '0, 1'b0, ER_TAG);
                    end
                end
                PH_VAR_INT, PH_VAR_STR, PH_VAR_REF, PH_VAR_TAB: begin
                    if (r_sh < 7'd64) vacc = r_acc | (64'(b[6:0]) << r_sh[5:0]);
                    n_acc = vacc;
                    if (!b[7]) begin
                        unique case (r_ph)
                            PH_VAR_INT: begin
                                do_cmp = 1'b1; ck = TK_INT;
                                cv = (vacc >> 1) ^ (64'd0 - {63'd0, vacc[0]});
                            end
                            PH_VAR_STR: begin
                                if (vacc > 64'(rem)) begin
                                    n_ph = PH_FAIL; n_ov = 1'b1;
                                    n_od = pack(TK_NONE, '0, '0, 1'b0, ER_STRUNC);
                                end else begin
                                    if (r_nstr != '1) n_nstr = r_nstr + 1'b1;
                                    if (vacc == '0) begin
                                        do_cmp = 1'b1; ck = TK_NEWSTR;
                                    end else begin
                                        n_pend = vacc[LENGTH_BITS-1:0]; n_ph = PH_STRB;
                                        n_ov = 1'b1;
                                        n_od = pack(TK_NEWSTR, vacc, '0, 1'b0, ER_NONE);
                                    end
                                end
                            end
                            PH_VAR_REF: begin
                                if (vacc >= 64'(r_nstr)) begin
                                    n_ph = PH_FAIL; n_ov = 1'b1;
                                    n_od = pack(TK_NONE, '0, '0, 1'b0, ER_REF);
                                end else begin
                                    do_cmp = 1'b1; ck = TK_STRREF; cv = vacc;
                                end
                            end
                            default: begin
                                if (vacc > 64'(rem >> 1)) begin
                                    n_ph = PH_FAIL; n_ov = 1'b1;
                                    n_od = pack(TK_NONE, '0, '0, 1'b0, ER_BIG);
                                end else if (vacc == '0) begin
                                    do_cmp = 1'b1; ck = TK_TABLE;
                                end else begin
                                    // Push: spill old top, new top held in register
                                    if (r_dep != '0) begin
                                        we = 1'b1; waddr = AW'(r_dep - 1'b1); wdata = r_top;
                                    end
                                    n_top = {vacc[LENGTH_BITS-1:0], 1'b0};
                                    n_dep = r_dep + 1'b1; n_ph = PH_TAG; n_ov = 1'b1;
                                    n_od = pack(TK_TABLE, vacc, '0, 1'b0, ER_NONE);
                                end
                            end
                        endcase
                    end else begin
                        n_sh = r_sh + 7'd7;
                        if (r_sh + 7'd7 >= 7'd64) begin
                            n_ph = PH_FAIL; n_ov = 1'b1;
                            n_od = pack(TK_NONE, '0, '0, 1'b0, ER_VLONG);
                        end else if (rem == '0) begin
                            n_ph = PH_FAIL; n_ov = 1'b1;
                            n_od = pack(TK_NONE, '0, '0, 1'b0, ER_VTRUNC);
                        end
                    end
                end
                PH_DOUBLE: begin
                    if (r_sh < 7'd64) vacc = r_acc | (64'(b) << r_sh[5:0]);
                    n_acc = vacc; n_sh = r_sh + 7'd8;
                    n_pend = (r_pend == '0) ? '0 : r_pend - 1'b1;
                    if (n_pend == '0) begin
                        do_cmp = 1'b1; ck = TK_DOUBLE; cv = vacc;
                    end else if (rem < n_pend) begin
                        n_ph = PH_FAIL; n_ov = 1'b1;
                        n_od = pack(TK_NONE, '0, '0, 1'b0, ER_DTRUNC);
                    end
                end
                PH_STRB: begin
                    n_pend = (r_pend == '0) ? '0 : r_pend - 1'b1;
                    if (n_pend == '0) begin
                        do_cmp = 1'b1; ck = TK_STRBYTE; cv = 64'(b);
                    end else if (rem < n_pend) begin
                        n_ph = PH_FAIL; n_ov = 1'b1;
                        n_od = pack(TK_NONE, '0, '0, 1'b0, ER_STRUNC);
                    end else begin
                        n_ov = 1'b1; n_od = pack(TK_STRBYTE, 64'(b), '0, 1'b0, ER_NONE);
                    end
                end
                default: ;
            endcase
        end

        // Completion: decide at the stack top, one level per cycle while output is free
        if (do_cmp) begin
            logic [LENGTH_BITS-1:0] crem;
            crem = r_casc ? r_crem : rem;
            owed = (top_cur == '0) ? '0 : top_cur - 1'b1;
            if (dep_cur == '0) begin
                n_casc = 1'b0; n_ov = 1'b1;
                if (crem != '0) begin
                    n_ph = PH_FAIL; n_od = pack(TK_NONE, '0, '0, 1'b0, ER_TRAIL);
                end else begin
                    n_ph = PH_DONE; n_od = pack(ck, cv, ccl, 1'b1, ER_NONE);
                end
            end else if (owed != '0) begin
                n_casc = 1'b0; n_ov = 1'b1; n_top = owed;
                if (crem == '0) begin
                    n_ph = PH_FAIL; n_od = pack(TK_NONE, '0, '0, 1'b0, ER_END);
                end else begin
                    n_ph = PH_TAG; n_od = pack(ck, cv, ccl, 1'b0, ER_NONE);
                end
            end else begin
                // Pop one level; fetch the next top if any
                n_dep = dep_cur - 1'b1; n_casc = 1'b1; n_ck = ck; n_cv = cv;
                n_crem = crem; n_ccl = ccl + 7'd1;
                if (dep_cur > DW'(1)) begin
                    raddr = AW'(dep_cur - DW'(2)); n_pop = 1'b1;
                end
            end
        end else if (r_casc) begin
            n_top = top_cur; n_pop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE; r_acc <= '0; r_sh <= '0; r_pend <= '0; r_nstr <= '0;
            r_dep <= '0; r_casc <= 1'b0; r_pop <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_ph <= n_ph; r_acc <= n_acc; r_sh <= n_sh; r_pend <= n_pend;
            r_nstr <= n_nstr; r_dep <= n_dep; r_casc <= n_casc; r_pop <= n_pop;
            r_ov <= n_ov;
        end
        r_top <= n_top; r_ck <= n_ck; r_cv <= n_cv; r_crem <= n_crem;
        r_ccl <= n_ccl; r_od <= n_od;
    end
endmodule

// ----- rtl/tvsd_ram.sv -----
module tvsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
